// ----- hw/rtl/lse_pkg.sv -----
`timescale 1ns / 1ps

package lse_pkg;

  // slot count and field widths
  localparam int SLOTS_MAX   = 8;
  localparam int SLOTS_DEF   = 8;
  localparam int EXT_MODULES = 3;
  localparam int RELAYS_PER  = 4;
  localparam int SLOT_W      = 3;
  localparam int MIN_W       = 11;
  localparam int TIME_W      = 14;
  localparam int GROUP_W     = 16;
  localparam int LOOP_W      = 16;
  localparam int RELAY_W     = 13;
  localparam int ONLINE_W    = 3;
  localparam int ENTRY_W     = 61;

  // slot entry layout
  localparam int START_LSB = 0;
  localparam int END_LSB   = 14;
  localparam int GROUP_LSB = 28;
  localparam int LOOP_LSB  = 44;
  localparam int VALID_BIT = 60;

  typedef enum logic [1:0] {
    EV_LOCAL_OPEN  = 2'd0,
    EV_LOCAL_CLOSE = 2'd1,
    EV_GROUP_OPEN  = 2'd2,
    EV_GROUP_CLOSE = 2'd3
  } event_kind_t;

  typedef struct packed {
    event_kind_t          kind;
    logic [SLOT_W-1:0]    slot;
    logic [RELAY_W-1:0]   relay;
    logic [GROUP_W-1:0]   group;
    logic [LOOP_W-1:0]    loop_word;
    logic                 last;
  } event_word_t;

  // forward link of the cell row: pending seen so far and the selected word
  typedef struct packed {
    logic        pend;
    event_word_t word;
  } chain_t;

  // start minute within one minute of the end minute
  function automatic logic near_minute(input logic [TIME_W-1:0] a,
                                       input logic [TIME_W-1:0] b);
    logic [TIME_W:0] a1;
    logic [TIME_W:0] b1;
    a1 = {1'b0, a} + 1'b1;
    b1 = {1'b0, b} + 1'b1;
    return (a == b) || (a1 == {1'b0, b}) || (b1 == {1'b0, a});
  endfunction

  // relay image of a local open: main relay plus online extension relays
  function automatic logic [RELAY_W-1:0] relay_map(input logic [LOOP_W-1:0] lw,
                                                   input logic [ONLINE_W-1:0] online);
    logic [RELAY_W-1:0] r;
    r = '0;
    r[0] = lw[0];
    for (int m = 0; m < EXT_MODULES; m++) begin
      for (int n = 0; n < RELAYS_PER; n++) begin
        r[1 + m * RELAYS_PER + n] = lw[1 + m * RELAYS_PER + n] & online[m];
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/lse_slot_cell.sv -----
`timescale 1ns / 1ps

module lse_slot_cell #(
  parameter int SLOTS = lse_pkg::SLOTS_DEF,
  parameter int IDX   = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lse_pkg::ENTRY_W-1:0]   cfg_data,
  input  logic                          tick_take,
  input  logic [lse_pkg::MIN_W-1:0]     now,
  input  logic [lse_pkg::ONLINE_W-1:0]  online,
  input  logic [lse_pkg::TIME_W-1:0]    starts [SLOTS],
  input  logic [lse_pkg::GROUP_W-1:0]   groups [SLOTS],
  input  logic                          out_take,
  input  lse_pkg::chain_t               fwd_in,
  output lse_pkg::chain_t               fwd_out,
  input  logic                          later_in,
  output logic                          later_out,
  output logic [lse_pkg::TIME_W-1:0]    start_min,
  output logic [lse_pkg::GROUP_W-1:0]   grp
);
  import lse_pkg::*;

  logic [ENTRY_W-1:0] entry;
  logic               start_fired;
  logic               end_fired;
  logic               open_pend;
  logic               close_pend;
  event_word_t        open_word;
  event_word_t        close_word;

  logic [TIME_W-1:0]  end_min;
  logic [LOOP_W-1:0]  lw;
  logic               slot_valid;
  logic               is_local;
  logic               match_s;
  logic               match_e;
  logic               keep;
  logic [GROUP_W-1:0] clr;
  logic               pend_any;
  logic               head;
  event_word_t        sel_word;

  // slot fields
  assign start_min  = entry[START_LSB +: TIME_W];
  assign end_min    = entry[END_LSB +: TIME_W];
  assign grp        = entry[GROUP_LSB +: GROUP_W];
  assign lw         = entry[LOOP_LSB +: LOOP_W];
  assign slot_valid = entry[VALID_BIT];
  assign is_local   = (grp == '0);
  assign match_s    = (TIME_W'(now) == start_min);
  assign match_e    = (TIME_W'(now) == end_min);

  // close suppression against the other slots' starts
  always_comb begin
    keep = 1'b0;
    clr  = '0;
    for (int j = 0; j < SLOTS; j++) begin
      if (j != IDX && near_minute(starts[j], end_min)) begin
        if (groups[j] == '0) keep = 1'b1;
        clr = clr | groups[j];
      end
    end
  end

  // latches and pending flags
  always_ff @(posedge clk) begin
    if (rst) begin
      entry       <= '0;
      start_fired <= 1'b0;
      end_fired   <= 1'b0;
      open_pend   <= 1'b0;
      close_pend  <= 1'b0;
    end else begin
      if (cfg_we) entry <= cfg_data;
      if (tick_take && slot_valid) begin
        if (match_s) begin
          if (!start_fired) begin
            start_fired <= 1'b1;
            open_pend   <= 1'b1;
          end
        end else begin
          start_fired <= 1'b0;
        end
        if (match_e) begin
          if (!end_fired) begin
            end_fired  <= 1'b1;
            close_pend <= !(is_local && keep);
          end
        end else begin
          end_fired <= 1'b0;
        end
      end else if (out_take && head) begin
        if (open_pend) open_pend <= 1'b0;
        else close_pend <= 1'b0;
      end
    end
  end

  // event words captured with the tick
  always_ff @(posedge clk) begin
    if (tick_take && slot_valid) begin
      open_word.kind       <= is_local ? EV_LOCAL_OPEN : EV_GROUP_OPEN;
      open_word.slot       <= SLOT_W'(IDX);
      open_word.relay      <= is_local ? relay_map(lw, online) : '0;
      open_word.group      <= is_local ? '0 : grp;
      open_word.loop_word  <= is_local ? '0 : lw;
      open_word.last       <= 1'b0;
      close_word.kind      <= is_local ? EV_LOCAL_CLOSE : EV_GROUP_CLOSE;
      close_word.slot      <= SLOT_W'(IDX);
      close_word.relay     <= '0;
      close_word.group     <= is_local ? '0 : (grp & ~clr);
      close_word.loop_word <= '0;
      close_word.last      <= 1'b0;
    end
  end

  // place in the row: first pending cell drives the word
  always_comb begin
    pend_any      = open_pend | close_pend;
    head          = pend_any && !fwd_in.pend;
    sel_word      = open_pend ? open_word : close_word;
    sel_word.last = !(open_pend && close_pend) && !later_in;
    later_out     = later_in | pend_any;
    fwd_out.pend  = fwd_in.pend | pend_any;
    fwd_out.word  = head ? sel_word : fwd_in.word;
  end

endmodule

// ----- hw/rtl/lamp_schedule_event_generator.sv -----
`timescale 1ns / 1ps
// first event appears in the cycle after the tick word is accepted
// events then leave one per cycle while out_ready is high: up to 2*SLOTS per tick
// no new tick word is accepted while events are pending; their order is set by the
// row of slot cells, which emits from the lowest slot still holding an event
// synchronous reset clears slot registers, match latches and pending events

module lamp_schedule_event_generator #(
  parameter int SLOTS = lse_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [lse_pkg::SLOT_W-1:0]    cfg_index,
  input  logic [lse_pkg::ENTRY_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lse_pkg::MIN_W-1:0]     minute_of_day,
  input  logic                          schedule_active,
  input  logic [lse_pkg::ONLINE_W-1:0]  ext_online,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    event_kind,
  output logic [lse_pkg::SLOT_W-1:0]    slot_index,
  output logic [lse_pkg::RELAY_W-1:0]   relay_state,
  output logic [lse_pkg::GROUP_W-1:0]   group_mask,
  output logic [lse_pkg::LOOP_W-1:0]    loop_word,
  output logic                          last_event
);
  import lse_pkg::*;

  chain_t             fwd   [SLOTS+1];
  logic               later [SLOTS+1];
  logic [TIME_W-1:0]  starts [SLOTS];
  logic [GROUP_W-1:0] groups [SLOTS];
  logic               tick_take;
  logic               out_take;

  // handshake
  assign in_ready  = !fwd[SLOTS].pend;
  assign tick_take = in_valid && in_ready && schedule_active;
  assign out_valid = fwd[SLOTS].pend;
  assign out_take  = out_valid && out_ready;

  // row ends
  assign fwd[0]       = '0;
  assign later[SLOTS] = 1'b0;

  // row of slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    lse_slot_cell #(
      .SLOTS (SLOTS),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cfg_we    (cfg_write && (cfg_index == SLOT_W'(i))),
      .cfg_data  (cfg_data),
      .tick_take (tick_take),
      .now       (minute_of_day),
      .online    (ext_online),
      .starts    (starts),
      .groups    (groups),
      .out_take  (out_take),
      .fwd_in    (fwd[i]),
      .fwd_out   (fwd[i+1]),
      .later_in  (later[i+1]),
      .later_out (later[i]),
      .start_min (starts[i]),
      .grp       (groups[i])
    );
  end

  // result word
  assign event_kind  = fwd[SLOTS].word.kind;
  assign slot_index  = fwd[SLOTS].word.slot;
  assign relay_state = fwd[SLOTS].word.relay;
  assign group_mask  = fwd[SLOTS].word.group;
  assign loop_word   = fwd[SLOTS].word.loop_word;
  assign last_event  = fwd[SLOTS].word.last;

endmodule
